// ===== rtl/dsqf_pkg.sv =====
package dsqf_pkg;

  localparam int PROBE_COUNT = 2;
  localparam int EXTRA_FRACTION_BITS = 8;

  localparam int RAW_W    = 12;
  localparam int SMOOTH_W = 20;
  localparam int GAIN_W   = 9;
  localparam int CNT_W    = 8;
  localparam int LIM_W    = 12;
  localparam int GAIN_SHIFT = 8;

  localparam int SCL_W = RAW_W + EXTRA_FRACTION_BITS;
  localparam int DIF_W = ((SCL_W > SMOOTH_W) ? SCL_W : SMOOTH_W) + 1;
  localparam int PRD_W = DIF_W + GAIN_W + 1;
  localparam int STP_W = PRD_W - GAIN_SHIFT;
  localparam int SUM_W = STP_W + 1;
  localparam int GAP_W = ((LIM_W + EXTRA_FRACTION_BITS) > (SMOOTH_W + 1)) ?
                         (LIM_W + EXTRA_FRACTION_BITS) : (SMOOTH_W + 1);

  localparam int SMOOTH_MAX = 2 ** (SMOOTH_W - 1) - 1;
  localparam int SMOOTH_MIN = -(2 ** (SMOOTH_W - 1));

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] REG_VALID_MIN      = 3'd0;
  localparam logic [ADDR_W-1:0] REG_VALID_MAX      = 3'd1;
  localparam logic [ADDR_W-1:0] REG_STEP_LIMIT     = 3'd2;
  localparam logic [ADDR_W-1:0] REG_FILTER_GAIN    = 3'd3;
  localparam logic [ADDR_W-1:0] REG_FAIL_LIMIT     = 3'd4;
  localparam logic [ADDR_W-1:0] REG_RECOVER_LIMIT  = 3'd5;
  localparam logic [ADDR_W-1:0] REG_MISMATCH_LIMIT = 3'd6;

  typedef struct packed {
    logic signed [RAW_W-1:0]  valid_min;
    logic signed [RAW_W-1:0]  valid_max;
    logic        [LIM_W-1:0]  step_limit;
    logic        [GAIN_W-1:0] filter_gain;
    logic        [CNT_W-1:0]  fail_limit;
    logic        [CNT_W-1:0]  recover_limit;
    logic        [LIM_W-1:0]  mismatch_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [SMOOTH_W-1:0] smooth;
    logic                       present;
    logic                       usable;
    logic                       broken;
  } lane_stat_t;

  typedef struct packed {
    lane_stat_t                 lane_a;
    lane_stat_t                 lane_b;
    logic signed [SMOOTH_W-1:0] fused_temp;
    logic                       fused_present;
    logic        [SMOOTH_W-1:0] probe_gap;
    logic                       gap_alarm;
  } result_t;

  function automatic logic signed [SMOOTH_W-1:0] sat_smooth(
    input logic signed [SUM_W-1:0] x
  );
    logic signed [SMOOTH_W-1:0] r;
    if (x > SUM_W'(SMOOTH_MAX)) begin
      r = SMOOTH_W'(SMOOTH_MAX);
    end else if (x < SUM_W'(SMOOTH_MIN)) begin
      r = SMOOTH_W'(SMOOTH_MIN);
    end else begin
      r = x[SMOOTH_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/dsqf_lane.sv =====
module dsqf_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic signed [dsqf_pkg::RAW_W-1:0] raw_i,
  input  logic                           gone_i,
  input  dsqf_pkg::cfg_t                 cfg_i,
  output dsqf_pkg::lane_stat_t           stat_o
);
  import dsqf_pkg::*;

  logic signed [SMOOTH_W-1:0] smooth_q, smooth_d;
  logic                       present_q, present_d;
  logic signed [RAW_W-1:0]    last_q, last_d;
  logic                       last_p_q, last_p_d;
  logic        [CNT_W-1:0]    fail_q, fail_d;
  logic        [CNT_W-1:0]    rec_q, rec_d;
  logic                       valid_q, valid_d;

  logic signed [RAW_W:0]      jump;
  logic        [RAW_W:0]      jump_abs;
  logic                       ok;
  logic signed [SCL_W-1:0]    scaled;
  logic signed [DIF_W-1:0]    diff;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [PRD_W-1:0]    prod;
  logic signed [STP_W-1:0]    step;
  logic signed [SUM_W-1:0]    sum;
  logic        [CNT_W-1:0]    fail_inc;
  logic        [CNT_W-1:0]    rec_inc;

  always_comb begin
    jump     = (RAW_W+1)'(raw_i) - (RAW_W+1)'(last_q);
    jump_abs = jump[RAW_W] ? $unsigned(-jump) : $unsigned(jump);
    ok = !gone_i && (raw_i >= cfg_i.valid_min) && (raw_i <= cfg_i.valid_max) &&
         !(last_p_q && (jump_abs > {1'b0, cfg_i.step_limit}));

    scaled = {raw_i, {EXTRA_FRACTION_BITS{1'b0}}};
    diff   = DIF_W'(scaled) - DIF_W'(smooth_q);
    gain_s = $signed({1'b0, cfg_i.filter_gain});
    prod   = PRD_W'(diff) * PRD_W'(gain_s);
    step   = $signed(prod[PRD_W-1:GAIN_SHIFT]);
    sum    = SUM_W'(smooth_q) + SUM_W'(step);

    fail_inc = (fail_q == CNT_MAX) ? fail_q : fail_q + 1'b1;
    rec_inc  = (rec_q == CNT_MAX) ? rec_q : rec_q + 1'b1;

    smooth_d  = smooth_q;
    present_d = present_q;
    last_d    = last_q;
    last_p_d  = last_p_q;
    fail_d    = fail_q;
    rec_d     = rec_q;
    valid_d   = valid_q;

    if (ok) begin
      last_d    = raw_i;
      last_p_d  = 1'b1;
      smooth_d  = present_q ? sat_smooth(sum) : sat_smooth(SUM_W'(scaled));
      present_d = 1'b1;
      fail_d    = '0;
      rec_d     = rec_inc;
      if (rec_inc >= cfg_i.recover_limit) begin
        valid_d = 1'b1;
      end
    end else begin
      rec_d  = '0;
      fail_d = fail_inc;
      if (fail_inc >= cfg_i.fail_limit) begin
        valid_d   = 1'b0;
        smooth_d  = '0;
        present_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q  <= '0;
      present_q <= 1'b0;
      last_q    <= '0;
      last_p_q  <= 1'b0;
      fail_q    <= '0;
      rec_q     <= '0;
      valid_q   <= 1'b0;
    end else if (en_i) begin
      smooth_q  <= smooth_d;
      present_q <= present_d;
      last_q    <= last_d;
      last_p_q  <= last_p_d;
      fail_q    <= fail_d;
      rec_q     <= rec_d;
      valid_q   <= valid_d;
    end
  end

  assign stat_o.smooth  = present_q ? smooth_q : '0;
  assign stat_o.present = present_q;
  assign stat_o.usable  = valid_q;
  assign stat_o.broken  = !valid_q && (fail_q >= cfg_i.fail_limit);

endmodule

// ===== rtl/dsqf_merge.sv =====
module dsqf_merge (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  dsqf_pkg::lane_stat_t          lane_a_i,
  input  dsqf_pkg::lane_stat_t          lane_b_i,
  input  logic [dsqf_pkg::LIM_W-1:0]    mismatch_limit_i,
  output dsqf_pkg::result_t             res_o
);
  import dsqf_pkg::*;

  result_t                    res_q, res_d;
  logic signed [SMOOTH_W:0]   pair_sum;
  logic signed [SMOOTH_W:0]   pair_dif;
  logic        [SMOOTH_W:0]   gap;
  logic        [GAP_W-1:0]    gap_lim;
  logic                       both;

  always_comb begin
    pair_sum = (SMOOTH_W+1)'(lane_a_i.smooth) + (SMOOTH_W+1)'(lane_b_i.smooth);
    pair_dif = (SMOOTH_W+1)'(lane_a_i.smooth) - (SMOOTH_W+1)'(lane_b_i.smooth);
    gap      = pair_dif[SMOOTH_W] ? $unsigned(-pair_dif) : $unsigned(pair_dif);
    gap_lim  = GAP_W'({mismatch_limit_i, {EXTRA_FRACTION_BITS{1'b0}}});
    both     = lane_a_i.usable && lane_b_i.usable;

    res_d.lane_a        = lane_a_i;
    res_d.lane_b        = lane_b_i;
    res_d.fused_present = lane_a_i.usable || lane_b_i.usable;
    res_d.probe_gap     = '0;
    res_d.gap_alarm     = 1'b0;
    if (both) begin
      res_d.fused_temp = pair_sum[SMOOTH_W:1];
      res_d.probe_gap  = gap[SMOOTH_W-1:0];
      res_d.gap_alarm  = GAP_W'(gap) > gap_lim;
    end else if (lane_a_i.usable) begin
      res_d.fused_temp = lane_a_i.smooth;
    end else if (lane_b_i.usable) begin
      res_d.fused_temp = lane_b_i.smooth;
    end else begin
      res_d.fused_temp = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/dual_sensor_qualify_fuse_core.sv =====
// Two-probe temperature qualifier and fuser.
// Input stream: one transfer carries a reading from each probe plus their
// disconnected flags. Each probe has its own lane holding its filter, last
// accepted reading and fail/recovery counters; a merge stage forms the fused
// temperature, the probe gap and the mismatch alarm.
// Output stream: one transfer per input transfer, in order.
// Pipeline: a result is registered in the lane stage and then in the merge stage
// before it is presented on the output stream.
// Throughput: one transfer per cycle while m_axis_tready is high; each lane's filter
// update (one multiply and add with saturation) completes in the cycle of acceptance.
// Configuration: write registers through cfg_we_i/cfg_addr_i/cfg_wdata_i while
// no transfer is in flight; writes are registered before they take effect.
// Reset: all lanes return to invalid with empty filters and cleared counters,
// registers return to their defaults, the output stream is empty.
// Stall: when the receiver holds m_axis_tready low the result holds, the lane
// stage keeps one further result, and s_axis_tready drops once both are full.
module dual_sensor_qualify_fuse_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // raw_a, raw_b
  input  logic [1:0]  s_axis_tuser,  // gone_a, gone_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // smooth_a, usable_a, broken_a, smooth_b, usable_b, broken_b,
  // fused_temp, probe_gap, gap_alarm, zero fill
  output logic [87:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,  // smooth_a_present, smooth_b_present, fused_present
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [11:0] cfg_wdata_i
);
  import dsqf_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       stage_q, stage_d;
  logic       out_q, out_d;
  logic       accept;
  logic       advance;
  lane_stat_t stat [PROBE_COUNT];
  result_t    res;
  logic signed [RAW_W-1:0] raw [PROBE_COUNT];
  logic        [PROBE_COUNT-1:0] gone;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_VALID_MIN:      cfg_d.valid_min      = $signed(cfg_wdata_i[RAW_W-1:0]);
        REG_VALID_MAX:      cfg_d.valid_max      = $signed(cfg_wdata_i[RAW_W-1:0]);
        REG_STEP_LIMIT:     cfg_d.step_limit     = cfg_wdata_i[LIM_W-1:0];
        REG_FILTER_GAIN:    cfg_d.filter_gain    = cfg_wdata_i[GAIN_W-1:0];
        REG_FAIL_LIMIT:     cfg_d.fail_limit     = cfg_wdata_i[CNT_W-1:0];
        REG_RECOVER_LIMIT:  cfg_d.recover_limit  = cfg_wdata_i[CNT_W-1:0];
        REG_MISMATCH_LIMIT: cfg_d.mismatch_limit = cfg_wdata_i[LIM_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.valid_min      <= -12'sd880;
      cfg_q.valid_max      <= 12'sd2000;
      cfg_q.step_limit     <= 12'd32;
      cfg_q.filter_gain    <= 9'd64;
      cfg_q.fail_limit     <= 8'd3;
      cfg_q.recover_limit  <= 8'd3;
      cfg_q.mismatch_limit <= 12'd16;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign advance       = stage_q && (!out_q || m_axis_tready);
  assign s_axis_tready = !stage_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign stage_d       = accept || (stage_q && !advance);
  assign out_d         = advance || (out_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      out_q   <= 1'b0;
    end else begin
      stage_q <= stage_d;
      out_q   <= out_d;
    end
  end

  assign raw[0]  = $signed(s_axis_tdata[RAW_W-1:0]);
  assign raw[1]  = $signed(s_axis_tdata[2*RAW_W-1:RAW_W]);
  assign gone    = s_axis_tuser;

  for (genvar g = 0; g < PROBE_COUNT; g++) begin : g_lane
    dsqf_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (accept),
      .raw_i  (raw[g]),
      .gone_i (gone[g]),
      .cfg_i  (cfg_q),
      .stat_o (stat[g])
    );
  end

  dsqf_merge u_merge (
    .clk_i            (clk_i),
    .load_i           (advance),
    .lane_a_i         (stat[0]),
    .lane_b_i         (stat[1]),
    .mismatch_limit_i (cfg_q.mismatch_limit),
    .res_o            (res)
  );

  assign m_axis_tvalid = out_q;
  assign m_axis_tdata  = {3'b000, res.gap_alarm, res.probe_gap, res.fused_temp,
                          res.lane_b.broken, res.lane_b.usable, res.lane_b.smooth,
                          res.lane_a.broken, res.lane_a.usable, res.lane_a.smooth};
  assign m_axis_tuser  = {res.fused_present, res.lane_b.present, res.lane_a.present};

endmodule

// ===== rtl/dsqf_checker.sv =====
module dsqf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_fused_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[63:44] == 20'd0)
    else $error("fused temperature without a usable probe");

  a_usable_has_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[20] && !m_axis_tuser[0] ||
                      m_axis_tdata[42] && !m_axis_tuser[1]) |-> 1'b0)
    else $error("usable probe without filtered value");

  a_gap_needs_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[84] || m_axis_tdata[83:64] != 20'd0) |->
      m_axis_tdata[20] && m_axis_tdata[42])
    else $error("gap reported without both probes usable");

  a_broken_not_usable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[21] && m_axis_tdata[20]) &&
                      !(m_axis_tdata[43] && m_axis_tdata[42]))
    else $error("probe both broken and usable");

endmodule

bind dual_sensor_qualify_fuse_core dsqf_checker u_dsqf_checker (.*);
